FILE: sv/sle_pkg.sv
`timescale 1ns / 1ps
package sle_pkg;

	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int POS_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_LOCATE = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_HOLD
	} state_t;

	typedef logic [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic              ins;
		logic              del;
		logic              get;
		logic              locate;
		logic [IDX_W-1:0]  slot;
		logic [POS_W-1:0]  len;
		elem_t             val;
	} cell_ctrl_t;

endpackage

FILE: sv/sequential_list_engine.sv
`timescale 1ns / 1ps
// result path: an accepted request is registered in the s1 stage (status_s1, len_s1
//   and the cell outputs), then in the output registers in ST_CALC, and is offered in ST_HOLD
// requests: no new request is taken before the previous result is taken,
//   the next request being accepted in the cycle its predecessor's result leaves
// reset: clears the list length and all handshake state; the element cells
//   are not cleared, entries past the length are never visible
module sequential_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [sle_pkg::CMD_W-1:0]   cmd,
	input  logic [sle_pkg::POS_W-1:0]   position,
	input  logic [sle_pkg::ELEM_W-1:0]  value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        status,
	output logic [sle_pkg::ELEM_W-1:0]  read_data,
	output logic [sle_pkg::POS_W-1:0]   found_position,
	output logic [sle_pkg::POS_W-1:0]   list_count,
	output logic                        is_empty
);
	import sle_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [POS_W-1:0] len_q;
	logic [POS_W-1:0] len_d;
	logic             err_d;
	logic             status_s1;
	logic [POS_W-1:0] len_s1;
	logic             accept;
	logic             pos_in_list;
	logic             pos_ins_ok;
	cell_ctrl_t       ctrl;

	elem_t            cell_data [DEPTH];
	elem_t            cell_rd [DEPTH];
	logic [DEPTH-1:0] cell_match;
	elem_t            red_data;
	logic [POS_W-1:0] red_found;

	elem_t            read_data_q;
	logic             status_q;
	logic [POS_W-1:0] found_q;
	logic [POS_W-1:0] count_q;

	assign accept      = req_valid && req_ready;
	assign pos_in_list = (position != '0) && (position <= len_q);
	assign pos_ins_ok  = (position != '0) && (position <= len_q + POS_W'(1))
		&& (len_q != POS_W'(DEPTH));

	// command decode
	always_comb begin
		ctrl        = '0;
		ctrl.slot   = IDX_W'(position - POS_W'(1));
		ctrl.len    = len_q;
		ctrl.val    = value;
		len_d       = len_q;
		err_d       = 1'b1;
		case (cmd_t'(cmd))
			CMD_GET: begin
				err_d    = !pos_in_list;
				ctrl.get = accept && pos_in_list;
			end
			CMD_LOCATE: begin
				err_d       = 1'b0;
				ctrl.locate = accept;
			end
			CMD_INSERT: begin
				err_d    = !pos_ins_ok;
				ctrl.ins = accept && pos_ins_ok;
				if (pos_ins_ok) begin
					len_d = len_q + POS_W'(1);
				end
			end
			CMD_DELETE: begin
				err_d    = !pos_in_list;
				ctrl.del = accept && pos_in_list;
				if (pos_in_list) begin
					len_d = len_q - POS_W'(1);
				end
			end
			CMD_CLEAR: begin
				err_d = 1'b0;
				len_d = '0;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		elem_t left_w;
		elem_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end
		sle_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.ctrl     (ctrl),
			.left     (left_w),
			.right    (right_w),
			.data     (cell_data[i]),
			.rd_s1    (cell_rd[i]),
			.match_s1 (cell_match[i])
		);
	end

	sle_reduce u_reduce (
		.rd        (cell_rd),
		.match     (cell_match),
		.read_data (red_data),
		.found     (red_found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				len_q <= len_d;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				res_valid = 1'b1;
				req_ready = res_ready;
				if (res_ready) begin
					state_d = req_valid ? ST_CALC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= err_d;
			len_s1    <= len_d;
		end
		if (state_q == ST_CALC) begin
			status_q    <= status_s1;
			read_data_q <= red_data;
			found_q     <= red_found;
			count_q     <= len_s1;
		end
	end

	assign status         = status_q;
	assign read_data      = read_data_q;
	assign found_position = found_q;
	assign list_count     = count_q;
	assign is_empty       = (count_q == '0);

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= POS_W'(DEPTH))
		else $error("list length above depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 res_valid)
		else $error("result missing two cycles after request");

	a_found_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (found_position != '0) |-> found_position <= list_count)
		else $error("found position beyond list length");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (read_data != '0) |-> !status && (found_position == '0))
		else $error("read data on failed or locate result");

endmodule

FILE: sv/sle_cell.sv
`timescale 1ns / 1ps
module sle_cell (
	input  logic               clk,
	input  logic [sle_pkg::IDX_W-1:0] idx,
	input  sle_pkg::cell_ctrl_t ctrl,
	input  sle_pkg::elem_t      left,
	input  sle_pkg::elem_t      right,
	output sle_pkg::elem_t      data,
	output sle_pkg::elem_t      rd_s1,
	output logic               match_s1
);
	import sle_pkg::*;

	elem_t data_q;
	elem_t data_d;
	logic  at_slot;
	logic  above_slot;
	logic  in_list;

	assign at_slot    = (idx == ctrl.slot);
	assign above_slot = (idx > ctrl.slot);
	assign in_list    = ({1'b0, idx} < ctrl.len);

	always_comb begin
		data_d = data_q;
		if (ctrl.ins && at_slot) begin
			data_d = ctrl.val;
		end else if (ctrl.ins && above_slot) begin
			data_d = left;
		end else if (ctrl.del && (at_slot || above_slot)) begin
			data_d = right;
		end
	end

	always_ff @(posedge clk) begin
		data_q   <= data_d;
		rd_s1    <= (ctrl.get && at_slot) ? data_q : '0;
		match_s1 <= ctrl.locate && in_list && (data_q == ctrl.val);
	end

	assign data = data_q;

endmodule

FILE: sv/sle_reduce.sv
`timescale 1ns / 1ps
module sle_reduce (
	input  sle_pkg::elem_t                 rd [sle_pkg::DEPTH],
	input  logic [sle_pkg::DEPTH-1:0]      match,
	output sle_pkg::elem_t                 read_data,
	output logic [sle_pkg::POS_W-1:0]      found
);
	import sle_pkg::*;

	logic [DEPTH-1:0] first_hit;

	// isolate lowest matching cell
	assign first_hit = match & (~match + DEPTH'(1));

	always_comb begin
		read_data = '0;
		found     = '0;
		for (int i = 0; i < DEPTH; i++) begin
			read_data = read_data | rd[i];
			if (first_hit[i]) begin
				found = found | POS_W'(i + 1);
			end
		end
	end

endmodule

FILE: dv/sequential_list_engine_tb.sv
`timescale 1ns / 1ps
module sequential_list_engine_tb;
	import sle_pkg::*;

	localparam int ITEMS       = 1800;
	localparam int CYCLE_LIMIT = 1000000;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		logic              drain;
		logic [CMD_W-1:0]  cmd;
		logic [POS_W-1:0]  position;
		elem_t             value;
	} list_req_t;

	typedef struct packed {
		logic              status;
		elem_t             read_data;
		logic [POS_W-1:0]  found_position;
		logic [POS_W-1:0]  list_count;
		logic              is_empty;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [CMD_W-1:0]  cmd = '0;
	logic [POS_W-1:0]  position = '0;
	elem_t             value = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic              status;
	elem_t             read_data;
	logic [POS_W-1:0]  found_position;
	logic [POS_W-1:0]  list_count;
	logic              is_empty;

	logic              req_taken = 1'b0;
	logic              res_taken = 1'b0;

	list_req_t         pending[$];
	list_result_t      expected[$];

	elem_t             list_mem [DEPTH];
	int                list_len = 0;
	elem_t             value_pool [8];
	int                gen_len = 0;
	int                planned = 0;

	int                send_gap = 0;
	int                send_calm = 0;
	int                sink_gap = 0;
	int                sink_calm = 0;

	int                accepted = 0;
	int                results_seen = 0;
	int                mismatches = 0;
	int                full_rejects = 0;
	int                peak_len = 0;
	int                cycles = 0;

	sequential_list_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.cmd            (cmd),
		.position       (position),
		.value          (value),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.status         (status),
		.read_data      (read_data),
		.found_position (found_position),
		.list_count     (list_count),
		.is_empty       (is_empty)
	);

	always #1 clk = ~clk;

	function automatic list_result_t apply_request(logic [CMD_W-1:0] c,
			logic [POS_W-1:0] p, elem_t v);
		list_result_t r;
		int pi;
		int k;
		r = '0;
		pi = int'(p);
		case (c)
		CMD_GET: begin
			if (pi >= 1 && pi <= list_len)
				r.read_data = list_mem[pi-1];
			else
				r.status = 1'b1;
		end
		CMD_LOCATE: begin
			for (k = 0; k < list_len && r.found_position == 0; k++)
				if (list_mem[k] == v)
					r.found_position = POS_W'(k + 1);
		end
		CMD_INSERT: begin
			if (list_len >= DEPTH)
				full_rejects++;
			if (pi < 1 || pi > list_len + 1 || list_len >= DEPTH) begin
				r.status = 1'b1;
			end else begin
				for (k = list_len; k >= pi; k--)
					list_mem[k] = list_mem[k-1];
				list_mem[pi-1] = v;
				list_len++;
			end
		end
		CMD_DELETE: begin
			if (pi < 1 || pi > list_len) begin
				r.status = 1'b1;
			end else begin
				for (k = pi; k < list_len; k++)
					list_mem[k-1] = list_mem[k];
				list_len--;
			end
		end
		CMD_CLEAR: list_len = 0;
		default: r.status = 1'b1;
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		r.list_count = POS_W'(list_len);
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic elem_t pick_value();
		if ($urandom_range(0, 1))
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic int pick_pos(int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 88 && hi >= 1)
			return $urandom_range(1, hi);
		r = $urandom_range(0, 2);
		if (r == 0)
			return 0;
		if (r == 1)
			return hi + 1;
		return $urandom_range(0, 127);
	endfunction

	task automatic add_req(logic [CMD_W-1:0] c, int p, elem_t v);
		list_req_t q;
		q.drain = 1'b0;
		q.cmd = c;
		q.position = p[POS_W-1:0];
		q.value = v;
		pending.push_back(q);
		planned++;
		case (c)
		CMD_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
		CMD_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
		CMD_CLEAR:  gen_len = 0;
		default: ;
		endcase
	endtask

	task automatic add_pause();
		list_req_t q;
		q.drain = 1'b1;
		q.cmd = CMD_GET;
		q.position = '0;
		q.value = '0;
		pending.push_back(q);
	endtask

	task automatic check_field(string name, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// request driver
	always @(negedge clk) begin : drive
		list_req_t cur;
		logic hold;
		logic go;
		hold = req_valid && !req_taken;
		go = 1'b0;
		if (arst_n && !hold) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending.size() > 0) begin
				if (pending[0].drain) begin
					if (expected.size() == 0)
						void'(pending.pop_front());
				end else begin
					cur = pending.pop_front();
					go = 1'b1;
					send_gap = next_gap(send_calm);
				end
			end
		end
		req_valid <= hold || go;
		if (go) begin
			cmd <= cur.cmd;
			position <= cur.position;
			value <= cur.value;
		end
	end

	// result sink
	always @(negedge clk) begin : sink
		logic rdy;
		if (res_taken)
			sink_gap = next_gap(sink_calm);
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		res_ready <= rdy;
	end

	// monitor and scoreboard
	always @(posedge clk) begin : watch
		list_result_t want;
		list_result_t got;
		req_taken <= arst_n && req_valid && req_ready;
		res_taken <= arst_n && res_valid && res_ready;
		if (arst_n && res_valid && res_ready) begin
			got.status = status;
			got.read_data = read_data;
			got.found_position = found_position;
			got.list_count = list_count;
			got.is_empty = is_empty;
			results_seen++;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				mismatches++;
			end else begin
				want = expected.pop_front();
				check_field("status", ELEM_W'(want.status), ELEM_W'(got.status));
				check_field("read_data", want.read_data, got.read_data);
				check_field("found_position", ELEM_W'(want.found_position),
					ELEM_W'(got.found_position));
				check_field("list_count", ELEM_W'(want.list_count),
					ELEM_W'(got.list_count));
				check_field("is_empty", ELEM_W'(want.is_empty), ELEM_W'(got.is_empty));
			end
		end
		if (arst_n && req_valid && req_ready) begin
			expected.push_back(apply_request(cmd, position, value));
			accepted++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int r;
		int k;
		logic paused_mid;
		paused_mid = 1'b0;
		for (k = 0; k < 6; k++)
			value_pool[k] = $urandom;
		value_pool[6] = '0;
		value_pool[7] = '1;

		// directed: empty list, bad positions, ends and middle, spare codes
		add_req(CMD_GET, 1, '0);
		add_req(CMD_DELETE, 1, '0);
		add_req(CMD_LOCATE, 0, '0);
		add_req(CMD_INSERT, 0, 32'h1111_1111);
		add_req(CMD_INSERT, 2, 32'h2222_2222);
		add_req(CMD_INSERT, 1, 32'h0000_0000);
		add_req(CMD_INSERT, 1, 32'hffff_ffff);
		add_req(CMD_INSERT, 3, 32'ha5a5_a5a5);
		add_req(CMD_INSERT, 2, 32'h1234_5678);
		add_req(CMD_GET, 0, '0);
		add_req(CMD_GET, 1, '0);
		add_req(CMD_GET, 4, '0);
		add_req(CMD_GET, 5, '0);
		add_req(CMD_LOCATE, 0, 32'h0000_0000);
		add_req(CMD_LOCATE, 0, 32'ha5a5_a5a5);
		add_req(CMD_LOCATE, 0, 32'hdead_beef);
		add_req(CMD_INSERT, 127, 32'h5a5a_5a5a);
		add_req(CMD_DELETE, 5, '0);
		add_req(CMD_DELETE, 0, '0);
		add_req(CMD_DELETE, 1, '0);
		add_req(CMD_DELETE, 3, '0);
		for (k = int'(CMD_SPARE_LO); k <= int'(CMD_SPARE_HI); k++)
			add_req(CMD_W'(k), 1, 32'hffff_ffff);
		add_req(CMD_CLEAR, 0, '0);
		add_req(CMD_GET, 1, '0);
		add_req(CMD_LOCATE, 0, 32'hffff_ffff);
		add_pause();

		while (planned < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				while (gen_len < DEPTH)
					add_req(CMD_INSERT, $urandom_range(1, gen_len + 1), pick_value());
				repeat (3)
					add_req(CMD_INSERT, $urandom_range(0, 127), pick_value());
				add_req(CMD_GET, DEPTH, '0);
				add_req(CMD_LOCATE, 0, pick_value());
				add_req(CMD_DELETE, DEPTH, '0);
			end else if (r < 12) begin
				while (gen_len > 0)
					add_req(CMD_DELETE, $urandom_range(1, gen_len), $urandom);
			end else begin
				repeat ($urandom_range(10, 40)) begin
					r = $urandom_range(0, 99);
					if (r < 35)
						add_req(CMD_INSERT, pick_pos(gen_len + 1), pick_value());
					else if (r < 55)
						add_req(CMD_DELETE, pick_pos(gen_len), pick_value());
					else if (r < 75)
						add_req(CMD_GET, pick_pos(gen_len), pick_value());
					else if (r < 93)
						add_req(CMD_LOCATE, pick_pos(gen_len), pick_value());
					else if (r < 95)
						add_req(CMD_CLEAR, pick_pos(gen_len), pick_value());
					else
						add_req(CMD_W'($urandom_range(int'(CMD_SPARE_LO),
							int'(CMD_SPARE_HI))), pick_pos(gen_len), pick_value());
				end
			end
			if (!paused_mid && planned > ITEMS / 2) begin
				add_pause();
				paused_mid = 1'b1;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || req_valid || expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected.size());
			mismatches++;
		end

		$display("%0d requests over all commands and spare codes, %0d results checked",
			accepted, results_seen);
		$display("list reached %0d entries, %0d inserts refused on a full list, %0d mismatches",
			peak_len, full_rejects, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sequential_list_engine.f
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sle_reduce.sv
sv/sequential_list_engine.sv
dv/sequential_list_engine_tb.sv
